@@ rtl/isp_pkg.sv @@
`default_nettype none

package isp_pkg;

	localparam int COUNT_BITS_DEF = 16;

	// Parse phase, one-hot
	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_SPACE   = 7'b0000010,
		PH_SIGNED  = 7'b0000100,
		PH_ZERO    = 7'b0001000,
		PH_ZERO_X  = 7'b0010000,
		PH_DIGITS  = 7'b0100000,
		PH_DONE    = 7'b1000000
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_S64 = 2'd0;
	localparam logic [1:0] KIND_U64 = 2'd1;
	localparam logic [1:0] KIND_S32 = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_BAD_BASE = 2'd2;
	localparam logic [1:0] ST_NO_DIGIT = 2'd3;

	// Configuration register indexes
	localparam logic REG_RADIX = 1'b0;
	localparam logic REG_KIND  = 1'b1;

	localparam logic [5:0] RADIX_RESET = 6'd10;

	// Per-subject parse state (counters travel separately, their width is a parameter)
	typedef struct packed {
		phase_t      phase;
		logic        neg;
		logic [63:0] mag;
		logic        ovf;
		logic        any;
		logic [5:0]  base;
		logic [1:0]  kind;
	} core_t;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] consumed;
		logic [1:0]  status;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/isp_step.sv @@
`default_nettype none

module isp_step #(
	parameter int COUNT_BITS = 16
) (
	input  isp_pkg::core_t          core_i,
	input  logic [COUNT_BITS-1:0]   pos_i,
	input  logic [COUNT_BITS-1:0]   end_i,
	input  logic [7:0]              ch,
	input  logic                    first,
	input  logic                    last,
	input  logic [5:0]              radix,
	input  logic [1:0]              result_kind,
	output isp_pkg::core_t          core_o,
	output logic [COUNT_BITS-1:0]   pos_o,
	output logic [COUNT_BITS-1:0]   end_o,
	output isp_pkg::result_t        result
);
	import isp_pkg::*;

	localparam logic [COUNT_BITS-1:0] CountMax = '1;
	localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7a;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5a;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChUpX   = 8'h58;

	// {valid, value} of an alphanumeric digit, value up to 35
	function automatic logic [6:0] char_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= ChZero && c <= ChNine) begin
			t = c - ChZero;
			return {1'b1, t[5:0]};
		end else if (c >= ChLowA && c <= ChLowZ) begin
			t = c - ChLowA + 8'd10;
			return {1'b1, t[5:0]};
		end else if (c >= ChUpA && c <= ChUpZ) begin
			t = c - ChUpA + 8'd10;
			return {1'b1, t[5:0]};
		end
		return 7'd0;
	endfunction

	core_t                 cur;
	core_t                 sel;
	core_t                 nxt;
	logic [COUNT_BITS-1:0] pos0;
	logic [COUNT_BITS-1:0] end0;
	logic [COUNT_BITS-1:0] next_pos;
	logic [COUNT_BITS-1:0] sel_end;
	logic [6:0]            cv;
	logic                  blank;
	logic [5:0]            base_eff;
	logic                  acc_en;
	logic [5:0]            acc_base;
	logic [5:0]            acc_d;
	logic [69:0]           prod;
	logic [63:0]           lim;

	// Open a new subject on a first mark or when idle
	always_comb begin
		cur  = core_i;
		pos0 = pos_i;
		end0 = end_i;
		if (first || core_i.phase == PH_IDLE) begin
			cur.neg  = 1'b0;
			cur.mag  = 64'd0;
			cur.ovf  = 1'b0;
			cur.any  = 1'b0;
			cur.base = radix;
			cur.kind = result_kind;
			cur.phase = (radix == 6'd1 || radix > 6'd36) ? PH_DONE : PH_SPACE;
			pos0 = '0;
			end0 = '0;
		end
	end

	assign next_pos = (pos0 < CountMax) ? pos0 + 1'b1 : CountMax;
	assign cv       = char_val(ch);
	assign blank    = (ch == ChSpace) || (ch >= 8'd9 && ch <= 8'd13);
	assign base_eff = (cur.base == 6'd0) ? 6'd10 : cur.base;

	always_comb begin
		sel      = cur;
		sel_end  = end0;
		acc_en   = 1'b0;
		acc_base = cur.base;
		acc_d    = cv[5:0];
		unique case (cur.phase)
			PH_SPACE, PH_SIGNED: begin
				if (cur.phase == PH_SPACE && blank) begin
					sel = cur;
				end else if (cur.phase == PH_SPACE && (ch == ChPlus || ch == ChMinus)) begin
					sel.neg   = (ch == ChMinus);
					sel.phase = PH_SIGNED;
				end else if (ch == ChZero && (cur.base == 6'd0 || cur.base == 6'd16)) begin
					sel.base  = (cur.base == 6'd0) ? 6'd8 : 6'd16;
					sel.any   = 1'b1;
					sel.mag   = 64'd0;
					sel_end   = next_pos;
					sel.phase = PH_ZERO;
				end else begin
					sel.base = base_eff;
					acc_base = base_eff;
					if (cv[6] && cv[5:0] < base_eff) acc_en = 1'b1;
					else sel.phase = PH_DONE;
				end
			end
			PH_ZERO: begin
				if (ch == ChLowX || ch == ChUpX) sel.phase = PH_ZERO_X;
				else if (cv[6] && cv[5:0] < cur.base) acc_en = 1'b1;
				else sel.phase = PH_DONE;
			end
			PH_ZERO_X: begin
				// the prefix stands only when a hex digit follows it
				acc_base = 6'd16;
				if (cv[6] && cv[5:0] < 6'd16) begin
					sel.base = 6'd16;
					acc_en   = 1'b1;
				end else begin
					sel.phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (cv[6] && cv[5:0] < cur.base) acc_en = 1'b1;
				else sel.phase = PH_DONE;
			end
			PH_IDLE, PH_DONE: sel = cur;
			default: sel = cur;
		endcase
	end

	// One multiply-add; checking the full product against the limit replaces a division
	assign prod = 70'(cur.mag) * 70'(acc_base) + 70'(acc_d);
	assign lim  = (cur.kind == KIND_U64) ? 64'hFFFF_FFFF_FFFF_FFFF : TopBit;

	always_comb begin
		nxt   = sel;
		end_o = sel_end;
		if (acc_en) begin
			nxt.any = 1'b1;
			if (!cur.ovf) begin
				if (prod > 70'(lim)) nxt.ovf = 1'b1;
				else nxt.mag = prod[63:0];
			end
			end_o     = next_pos;
			nxt.phase = PH_DIGITS;
		end
		core_o = nxt;
		if (last) core_o.phase = PH_IDLE;
	end

	assign pos_o = next_pos;

	logic [63:0] mag_s;
	logic [63:0] v;
	logic [1:0]  st;
	logic [31:0] end32;

	assign end32 = 32'(end_o);
	assign mag_s = nxt.ovf ? TopBit : nxt.mag;

	always_comb begin
		v  = 64'd0;
		st = ST_OK;
		result.consumed = 16'd0;
		if (nxt.base == 6'd1 || nxt.base > 6'd36) begin
			st = ST_BAD_BASE;
		end else if (!nxt.any) begin
			st = ST_NO_DIGIT;
		end else begin
			result.consumed = (end32 > 32'h0000_FFFF) ? 16'hFFFF : end32[15:0];
			if (nxt.kind == KIND_U64) begin
				if (nxt.ovf) begin
					v  = 64'hFFFF_FFFF_FFFF_FFFF;
					st = ST_RANGE;
				end else begin
					v = nxt.neg ? 64'd0 - nxt.mag : nxt.mag;
				end
			end else begin
				if (nxt.neg) begin
					if (mag_s >= TopBit) begin
						v  = TopBit;
						st = nxt.ovf ? ST_RANGE : ST_OK;
					end else begin
						v = 64'd0 - mag_s;
					end
				end else if (mag_s > TopBit - 64'd1) begin
					v  = TopBit - 64'd1;
					st = ST_RANGE;
				end else begin
					v = mag_s;
				end
				if (nxt.kind == KIND_S32) begin
					if (v[63]) begin
						if (v < 64'hFFFF_FFFF_8000_0000) begin
							v  = 64'hFFFF_FFFF_8000_0000;
							st = ST_RANGE;
						end
					end else if (v > 64'h0000_0000_7FFF_FFFF) begin
						v  = 64'h0000_0000_7FFF_FFFF;
						st = ST_RANGE;
					end
				end
			end
		end
		result.value  = v;
		result.status = st;
	end

endmodule

`default_nettype wire

@@ rtl/integer_string_parser.sv @@
`default_nettype none

// Streaming integer parser in the style of strtol, strtoul and atoi. Send the
// characters of each subject string one per word on s_tdata; mark the first
// character with s_tuser and the final one with s_tlast (a NUL is assumed to
// follow it). Leading white space and one sign are skipped; radix 0 picks the
// base from a 0x or 0 prefix, and radix 16 skips a 0x prefix that a hex digit
// follows. Exactly one result word leaves on m_tdata per subject, on the word
// after its tlast character: the 64-bit value, then the 16-bit consumed count
// (through the last converted character, saturating), with the status on
// m_tuser. The block takes one character per clock cycle without gaps; the
// result waits in an output register while the next subject streams in, and
// only a final character stalls, for as long as the previous result is not
// taken. Each word passes through the input register and its result through
// the output register; the per-cycle path is the 64x6 multiply-add
// and limit compare of the digit accumulator. Write radix and result_kind
// only between subjects, while no result is pending.
module integer_string_parser #(
	parameter int COUNT_BITS = isp_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,  // 0 radix, 1 result_kind
	input  logic [5:0]  cfg_data,
	// character stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] ch
	input  logic        s_tuser,    // [0] first
	input  logic        s_tlast,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,    // [63:0] value, [79:64] consumed
	output logic [1:0]  m_tuser     // [1:0] status
);
	import isp_pkg::*;

	// configuration registers
	logic [5:0] radix_q;
	logic [1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			kind_q  <= KIND_S64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIX: radix_q <= cfg_data;
				REG_KIND:  kind_q  <= cfg_data[1:0];
				default:   radix_q <= radix_q;
			endcase
		end
	end

	// input register
	logic       s1_valid;
	logic [7:0] ch_s1;
	logic       first_s1;
	logic       last_s1;
	logic       fire;

	// A non-final character never waits on the result side; a final one needs
	// the output register free or draining this cycle.
	assign fire     = s1_valid && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !s1_valid || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid <= 1'b1;
		end else if (fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1    <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// parse state
	core_t                 core_q;
	logic [COUNT_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0] end_q;
	core_t                 core_d;
	logic [COUNT_BITS-1:0] pos_d;
	logic [COUNT_BITS-1:0] end_d;
	result_t               res_d;

	isp_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.core_i      (core_q),
		.pos_i       (pos_q),
		.end_i       (end_q),
		.ch          (ch_s1),
		.first       (first_s1),
		.last        (last_s1),
		.radix       (radix_q),
		.result_kind (kind_q),
		.core_o      (core_d),
		.pos_o       (pos_d),
		.end_o       (end_d),
		.result      (res_d)
	);

	// advance the parse state once per consumed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q <= '{phase: PH_IDLE, neg: 1'b0, mag: 64'd0, ovf: 1'b0, any: 1'b0,
				base: 6'd0, kind: KIND_S64};
			pos_q  <= '0;
			end_q  <= '0;
		end else if (fire) begin
			core_q <= core_d;
			pos_q  <= pos_d;
			end_q  <= end_d;
		end
	end

	// output register: hold the result until it is taken
	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic [1:0]  out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			out_data_q <= {res_d.consumed, res_d.value};
			out_user_q <= res_d.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	// a final character always produces a result word on the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> m_tvalid)
		else $error("final character did not produce a result");

	// a result word appears only after a final character
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(fire && last_s1))
		else $error("result without a final character");

	// failed conversions report zero value and zero count
	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_BAD_BASE || m_tuser == ST_NO_DIGIT))
		|-> (m_tdata == 80'd0))
		else $error("failed conversion with nonzero payload");

	// a held character is not overwritten before it is consumed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !fire) |=> (s1_valid && $stable(ch_s1) && $stable(last_s1)))
		else $error("input register overwritten");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	import isp_pkg::*;

	// Result kind 3 has no name in the package; it parses as the signed 64-bit kind
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int MAX_BASE      = 36;
	localparam int COUNT_MAX     = (1 << COUNT_BITS_DEF) - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int NUM_SETTINGS  = 12;
	localparam int CYCLE_LIMIT   = 800000;

	localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] S32_MIN = 64'hFFFF_FFFF_8000_0000;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
		logic       last;
	} char_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [5:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] ch
	logic        s_tuser;    // [0] first
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;    // [63:0] value, [79:64] consumed
	logic [1:0]  m_tuser;    // [1:0] status

	integer_string_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Characters waiting to be driven, and parse results still owed by the block
	char_word_t pending_chars[$];
	result_t    expected_results[$];

	int chars_queued   = 0;
	int chars_accepted = 0;
	int results_seen   = 0;
	int failures       = 0;
	int cycle_count    = 0;
	int gap_left       = 0;
	int stall_left     = 0;
	bit no_idle        = 0;
	bit word_taken     = 0;

	// Register values as last written
	logic [5:0] cfg_radix;
	logic [1:0] cfg_kind;

	// Parser state of the prediction, one subject at a time
	phase_t      pk_phase;
	logic        pk_neg;
	logic [63:0] pk_mag;
	logic        pk_ovf;
	logic        pk_any;
	logic [5:0]  pk_base;
	logic [1:0]  pk_kind;
	int          pk_pos;
	int          pk_end;

	always #5 clk = ~clk;

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int idle_len(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Value of an alphanumeric character, or -1 if it is no digit of this base
	function automatic int digit_of(byte unsigned c, int base);
		int v;
		if (c >= "0" && c <= "9")
			v = c - "0";
		else if (c >= "a" && c <= "z")
			v = c - "a" + 10;
		else if (c >= "A" && c <= "Z")
			v = c - "A" + 10;
		else
			return -1;
		return (v < base) ? v : -1;
	endfunction

	function automatic byte unsigned digit_char(int v);
		if (v < 10)
			return 8'(v) + "0";
		return 8'(v - 10) + ($urandom_range(0, 1) ? "a" : "A");
	endfunction

	task automatic push_char(byte unsigned c, bit is_first, bit is_last);
		pending_chars.push_back('{ch: c, first: is_first, last: is_last});
		chars_queued++;
	endtask

	// Fold one digit into the magnitude; latch overflow past the kind's limit
	task automatic add_digit(int d, int nxt);
		logic [63:0] lim;
		lim = (pk_kind == KIND_U64) ? '1 : TOP_BIT;
		pk_any = 1'b1;
		if (!pk_ovf) begin
			if (pk_mag > (lim - 64'(d)) / 64'(pk_base))
				pk_ovf = 1'b1;
			else
				pk_mag = pk_mag * 64'(pk_base) + 64'(d);
		end
		pk_end = nxt;
		pk_phase = PH_DIGITS;
	endtask

	task automatic digit_or_stop(byte unsigned c, int nxt);
		int d;
		d = digit_of(c, pk_base);
		if (d < 0)
			pk_phase = PH_DONE;
		else
			add_digit(d, nxt);
	endtask

	// Advance the parse by one accepted character; owe a result on the final one
	task automatic predict_char(byte unsigned c, bit is_first, bit is_last);
		int          nxt;
		int          d;
		result_t     res;
		logic [63:0] sv;
		if (is_first || pk_phase == PH_IDLE) begin
			// A new subject latches both registers; a dropped open subject owes nothing
			pk_neg  = 1'b0;
			pk_mag  = '0;
			pk_ovf  = 1'b0;
			pk_any  = 1'b0;
			pk_base = cfg_radix;
			pk_kind = cfg_kind;
			pk_pos  = 0;
			pk_end  = 0;
			pk_phase = (pk_base == 1 || pk_base > MAX_BASE) ? PH_DONE : PH_SPACE;
		end
		nxt = (pk_pos < COUNT_MAX) ? pk_pos + 1 : COUNT_MAX;
		case (pk_phase)
			PH_SPACE, PH_SIGNED: begin
				if (pk_phase == PH_SPACE && (c == " " || (c >= 8'd9 && c <= 8'd13))) begin
					// blank before the sign: stay
				end else if (pk_phase == PH_SPACE && (c == "+" || c == "-")) begin
					pk_neg = (c == "-");
					pk_phase = PH_SIGNED;
				end else if (c == "0" && (pk_base == 0 || pk_base == 16)) begin
					// a leading zero counts as converted even if an x follows it
					pk_base = (pk_base == 0) ? 6'd8 : 6'd16;
					pk_any = 1'b1;
					pk_mag = '0;
					pk_end = nxt;
					pk_phase = PH_ZERO;
				end else begin
					if (pk_base == 0)
						pk_base = 6'd10;
					digit_or_stop(c, nxt);
				end
			end
			PH_ZERO: begin
				if (c == "x" || c == "X")
					pk_phase = PH_ZERO_X;
				else
					digit_or_stop(c, nxt);
			end
			PH_ZERO_X: begin
				// the prefix only holds when a hex digit follows it
				d = digit_of(c, 16);
				if (d < 0)
					pk_phase = PH_DONE;
				else begin
					pk_base = 6'd16;
					add_digit(d, nxt);
				end
			end
			PH_DIGITS: digit_or_stop(c, nxt);
			default: begin
			end
		endcase
		pk_pos = nxt;

		if (is_last) begin
			res.value = '0;
			res.consumed = '0;
			if (pk_base == 1 || pk_base > MAX_BASE)
				res.status = ST_BAD_BASE;
			else if (!pk_any)
				res.status = ST_NO_DIGIT;
			else begin
				// pk_end already saturates at the counter's top
				res.consumed = 16'(pk_end);
				if (pk_kind == KIND_U64) begin
					if (pk_ovf) begin
						res.value = '1;
						res.status = ST_RANGE;
					end else begin
						res.value = pk_neg ? 64'd0 - pk_mag : pk_mag;
						res.status = ST_OK;
					end
				end else begin
					sv = pk_ovf ? TOP_BIT : pk_mag;
					res.status = ST_OK;
					if (pk_neg) begin
						if (sv >= TOP_BIT) begin
							res.value = TOP_BIT;
							if (pk_ovf)
								res.status = ST_RANGE;
						end else
							res.value = 64'd0 - sv;
					end else if (sv > TOP_BIT - 1) begin
						res.value = TOP_BIT - 1;
						res.status = ST_RANGE;
					end else
						res.value = sv;
					// 32-bit kind: clamp the 64-bit result to the int range
					if (pk_kind == KIND_S32) begin
						if (res.value[63]) begin
							if (res.value < S32_MIN) begin
								res.value = S32_MIN;
								res.status = ST_RANGE;
							end
						end else if (res.value > S32_MAX) begin
							res.value = S32_MAX;
							res.status = ST_RANGE;
						end
					end
				end
			end
			expected_results.push_back(res);
			pk_phase = PH_IDLE;
		end
	endtask

	// Build one subject string for the current radix and queue its characters.
	// Most are well formed: blanks, sign, prefix, digits, trailing junk. A few are
	// raw bytes, some sit right at a range limit, and some lack the first or last
	// mark or restart in the middle. close forces the last mark on the final one.
	task automatic queue_subject(bit close);
		byte unsigned txt[$];
		byte unsigned digs[$];
		int          r;
		int          eb;
		int          n_dig;
		int          cut;
		logic [63:0] num;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(1, 10))
				txt.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					n_dig = $urandom_range(0, 5);
					txt.push_back((n_dig == 5) ? 8'h20 : 8'(9 + n_dig));
				end
			end
			case ($urandom_range(0, 3))
				0: txt.push_back("-");
				1: txt.push_back("+");
				default: begin
				end
			endcase
			eb = (cfg_radix >= 2 && cfg_radix <= MAX_BASE) ? int'(cfg_radix) : 10;
			if (cfg_radix == 0 || cfg_radix == 16) begin
				case ($urandom_range(0, 5))
					0: begin
						txt.push_back("0");
						if (cfg_radix == 0)
							eb = 8;
					end
					1, 2: begin
						txt.push_back("0");
						txt.push_back($urandom_range(0, 1) ? "x" : "X");
						eb = 16;
					end
					default: begin
					end
				endcase
			end
			if (r < 18) begin
				// land on or next to a range limit of one of the kinds
				case ($urandom_range(0, 7))
					0: num = 64'h7FFF_FFFF_FFFF_FFFF;
					1: num = TOP_BIT;
					2: num = '1;
					3: num = S32_MAX;
					4: num = 64'h0000_0000_8000_0000;
					5: num = 64'h0000_0000_FFFF_FFFF;
					6: num = 64'h0000_0001_0000_0000;
					default: num = {$urandom, $urandom};
				endcase
				num = num + $urandom_range(0, 4) - 2;
				do begin
					digs.push_front(digit_char(int'(num % 64'(eb))));
					num = num / 64'(eb);
				end while (num != 0);
				foreach (digs[i])
					txt.push_back(digs[i]);
			end else begin
				// long runs can overflow every kind, an empty run tests no digits
				n_dig = (r < 60) ? $urandom_range(1, 6) :
				        (r < 82) ? $urandom_range(7, 20) :
				        (r < 94) ? $urandom_range(21, 70) : 0;
				repeat (n_dig)
					txt.push_back(($urandom_range(0, 19) == 0) ?
					              8'($urandom_range(8'h30, 8'h7a)) :
					              digit_char($urandom_range(0, eb - 1)));
			end
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4))
					txt.push_back(8'($urandom_range(0, 255)));
		end
		if (txt.size() == 0)
			txt.push_back(8'($urandom_range(0, 255)));
		cut = ($urandom_range(0, 29) == 0) ? $urandom_range(0, txt.size() - 1) : -1;
		foreach (txt[i])
			push_char(txt[i], (i == 0 && $urandom_range(0, 11) != 0) || i == cut,
			          i == txt.size() - 1 && (close || $urandom_range(0, 19) != 0));
	endtask

	task automatic write_reg(logic idx, logic [5:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RADIX)
			cfg_radix = val;
		else
			cfg_kind = val[1:0];
	endtask

	// Hold until every queued word is taken and every result is back, then let
	// the pipeline settle in case the final word owed nothing
	task automatic wait_idle();
		while (chars_accepted != chars_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Character driver: advance only once the current word is taken
	always @(negedge clk) begin
		char_word_t w;
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_chars.size() != 0) begin
				w = pending_chars.pop_front();
				s_tdata  <= w.ch;
				s_tuser  <= w.first;
				s_tlast  <= w.last;
				s_tvalid <= 1'b1;
				gap_left = idle_len(no_idle);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (no_idle || $urandom_range(0, 99) < 70)
			m_tready <= 1'b1;
		else begin
			stall_left = idle_len(1'b0);
			m_tready <= 1'b0;
		end
	end

	// Monitor: check the result word first, then fold in the accepted character
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: value %h, consumed %0d, status %0d",
					       m_tdata[63:0], m_tdata[79:64], m_tuser);
					failures++;
				end else begin
					want = expected_results.pop_front();
					results_seen++;
					if (m_tdata[63:0] !== want.value) begin
						$error("value: expected %h, got %h", want.value, m_tdata[63:0]);
						failures++;
					end
					if (m_tdata[79:64] !== want.consumed) begin
						$error("consumed: expected %0d, got %0d", want.consumed, m_tdata[79:64]);
						failures++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						failures++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_char(s_tdata, s_tuser, s_tlast);
				chars_accepted++;
			end
			word_taken = s_tvalid && s_tready;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int         ph;
		int         budget;
		int         start;
		bit         paused;
		logic [5:0] rad;
		logic [1:0] knd;

		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_RADIX;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		cfg_radix = RADIX_RESET;
		cfg_kind  = KIND_S64;
		pk_phase  = PH_IDLE;
		pk_neg    = 1'b0;
		pk_mag    = '0;
		pk_ovf    = 1'b0;
		pk_any    = 1'b0;
		pk_base   = '0;
		pk_kind   = KIND_S64;
		pk_pos    = 0;
		pk_end    = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: decimal, signed 64-bit
		// blanks and a plus sign before the number
		push_char(" ", 1, 0);
		push_char(8'h09, 0, 0);
		push_char("+", 0, 0);
		push_char("7", 0, 1);
		// characters after the number are ignored
		push_char("-", 1, 0);
		push_char("9", 0, 0);
		push_char("x", 0, 1);
		// top byte value alone: no digits
		push_char(8'hFF, 1, 1);
		// no first mark while idle still opens a subject
		push_char("5", 0, 1);
		// a first mark mid-subject drops the open one
		push_char("1", 1, 0);
		push_char("2", 1, 1);
		// NUL stops the number
		push_char("3", 1, 0);
		push_char(8'h00, 0, 0);
		push_char("4", 0, 1);

		for (ph = 0; ph < NUM_SETTINGS; ph++) begin
			budget = 180;
			case (ph)
				0: begin rad = 6'd0;  knd = KIND_S64;   end
				1: begin rad = 6'd0;  knd = KIND_U64;   end
				2: begin rad = 6'd16; knd = KIND_S32;   end
				3: begin rad = 6'd10; knd = KIND_SPARE; end
				4: begin rad = 6'd2;  knd = KIND_S64;   end
				5: begin rad = 6'd36; knd = KIND_U64;   end
				6: begin rad = 6'd8;  knd = KIND_S32;   end
				7: begin rad = 6'd1;  knd = KIND_S64;   budget = 30; end
				8: begin rad = 6'd37; knd = KIND_U64;   budget = 30; end
				9: begin rad = 6'd63; knd = KIND_SPARE; budget = 30; end
				10: begin
					rad = 6'($urandom_range(2, MAX_BASE));
					knd = 2'($urandom_range(KIND_S64, KIND_SPARE));
				end
				default: begin rad = 6'd16; knd = KIND_U64; end
			endcase

			// registers change only with the block idle
			wait_idle();
			write_reg(REG_RADIX, rad);
			write_reg(REG_KIND, 6'(knd));
			no_idle = (ph == 3);

			if (ph == 0) begin
				// base detection: 0X then hex digits
				push_char("0", 1, 0);
				push_char("X", 0, 0);
				push_char("1", 0, 0);
				push_char("f", 0, 1);
				// dangling prefix at the end and before a non-hex letter
				push_char("0", 1, 0);
				push_char("x", 0, 1);
				push_char("0", 1, 0);
				push_char("x", 0, 0);
				push_char("g", 0, 1);
			end

			start = chars_queued;
			paused = 1'b0;
			while (chars_queued - start < budget) begin
				queue_subject(1'b0);
				// halfway through, drain everything before sending more
				if (!paused && chars_queued - start >= budget / 2) begin
					wait_idle();
					paused = 1'b1;
				end
			end
			queue_subject(1'b1);
		end

		wait_idle();
		$display("Checked %0d parse results from %0d characters under %0d register settings,",
		         results_seen, chars_accepted, NUM_SETTINGS + 1);
		$display("with base detection, invalid bases, range limits and gap-free streaming.");
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ integer_string_parser.f @@
rtl/isp_pkg.sv
rtl/isp_step.sv
rtl/integer_string_parser.sv
bench/tb_top.sv
